// ===== sv/qte_pkg.sv =====
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NSTEP        = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int CORDIC_LAT   = NSTEP + 1;

  localparam int VW = 38;  // cordic vector width
  localparam int ZW = 34;  // q30 angle width

  localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [24:0]   INV_GAIN_Q24 = 25'sd10188012;
  localparam logic signed [30:0]   DEG_Q24      = 31'sd961263669;
  localparam logic signed [24:0]   ANGLE_LIMIT  = 25'sd11796480;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_beat_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

// ===== sv/qte_cell.sv =====
module qte_cell
  import qte_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  logic [4:0]   step_idx,
  input  cordic_beat_t din,
  output cordic_beat_t dout
);

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  cordic_beat_t         nxt;

  always_comb begin
    xs = din.x >>> step_idx;
    ys = din.y >>> step_idx;
    nxt = din;
    // rotate toward the x axis
    if (din.y < 0) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - atan_q30(step_idx);
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + atan_q30(step_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== sv/qte_cordic.sv =====
module qte_cordic
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] vec_x,
  input  logic signed [VW-1:0] vec_y,
  output logic signed [ZW-1:0] angle,
  output logic signed [VW-1:0] mag
);

  cordic_beat_t chain [NSTEP+1];
  cordic_beat_t prep;

  // fold the left half plane over by pi
  always_comb begin
    prep.zero = (vec_x == '0) && (vec_y == '0);
    prep.x    = vec_x;
    prep.y    = vec_y;
    prep.z    = '0;
    if (vec_x < 0) begin
      prep.x = -vec_x;
      prep.y = -vec_y;
      prep.z = (vec_y >= 0) ? PI_Q30 : -PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= prep;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    qte_cell u_cell (
      .clk      (clk),
      .en       (en),
      .step_idx (5'(i)),
      .din      (chain[i]),
      .dout     (chain[i+1])
    );
  end

  assign angle = chain[NSTEP].zero ? '0 : chain[NSTEP].z;
  assign mag   = chain[NSTEP].zero ? '0 : chain[NSTEP].x;

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// quaternion to z-y-x euler angles: one q1.14 quaternion per beat in, one
// beat of roll, pitch and yaw (signed, 16 fraction bits, radians or degrees
// per output_in_degrees) out. a new beat is taken every cycle in which the
// pipeline advances; its depth is set by the two cordic cell chains that run one
// after the other (roll and yaw side by side, then pitch from the magnitude).
// the whole pipeline advances while the output register is free or taken.
module quaternion_to_euler_angles
  import qte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
  input  logic        cfg_we,
  input  logic [0:0]  cfg_wdata       // output_in_degrees
);

  localparam int NLAT = 2 * CORDIC_LAT + 6;
  localparam int DLY  = CORDIC_LAT + 2;

  logic output_in_degrees;
  logic en;
  logic [NLAT-1:0] vld;

  // global advance: output register empty or being drained
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      output_in_degrees <= 1'b0;
    end else if (cfg_we) begin
      output_in_degrees <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NLAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: quaternion products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] p_ww, p_xx, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_zz <= qz * qz;
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      p_xz <= qx * qz;
      p_wy <= qw * qy;
      p_yz <= qy * qz;
      p_wx <= qw * qx;
    end
  end

  // stage 2: rotation matrix terms at q28
  logic signed [VW-1:0] r11, r21, r31, r32, r33;
  localparam logic signed [VW-1:0] ONE_Q28 = VW'(1) <<< 28;

  always_ff @(posedge clk) begin
    if (en) begin
      r11 <= (VW'(p_ww) <<< 1) - ONE_Q28 + (VW'(p_xx) <<< 1);
      r33 <= (VW'(p_ww) <<< 1) - ONE_Q28 + (VW'(p_zz) <<< 1);
      r21 <= (VW'(p_xy) - VW'(p_wz)) <<< 1;
      r31 <= (VW'(p_xz) + VW'(p_wy)) <<< 1;
      r32 <= (VW'(p_yz) - VW'(p_wx)) <<< 1;
    end
  end

  // roll and yaw chains side by side
  logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;
  logic signed [VW-1:0] roll_mag, yaw_mag, pitch_mag;

  qte_cordic u_roll (
    .clk(clk), .en(en), .vec_x(r33), .vec_y(r32), .angle(roll_z), .mag(roll_mag)
  );

  qte_cordic u_yaw (
    .clk(clk), .en(en), .vec_x(r11), .vec_y(r21), .angle(yaw_z), .mag(yaw_mag)
  );

  // magnitude gain correction, split into two partial products
  logic signed [44:0] mg_hi;
  logic signed [44:0] mg_lo;
  logic signed [63:0] mg_sum;
  logic signed [VW-1:0] mag_q28;

  always_ff @(posedge clk) begin
    if (en) begin
      mg_hi <= 45'(roll_mag[VW-1:19] * INV_GAIN_Q24);
      mg_lo <= 45'($signed({1'b0, roll_mag[18:0]}) * INV_GAIN_Q24);
    end
  end

  assign mg_sum = (64'(mg_hi) <<< 19) + 64'(mg_lo) + (64'sd1 <<< 23);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_q28 <= VW'(mg_sum >>> 24);
    end
  end

  // side data carried alongside the cordic chains
  logic signed [VW-1:0] r31_dly  [DLY];
  logic signed [ZW-1:0] roll_dly [DLY];
  logic signed [ZW-1:0] yaw_dly  [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      r31_dly[0]  <= r31;
      roll_dly[0] <= roll_z;
      yaw_dly[0]  <= yaw_z;
      for (int i = 1; i < DLY; i++) begin
        r31_dly[i]  <= r31_dly[i-1];
        roll_dly[i] <= roll_dly[i-1];
        yaw_dly[i]  <= yaw_dly[i-1];
      end
    end
  end

  qte_cordic u_pitch (
    .clk(clk), .en(en), .vec_x(mag_q28), .vec_y(-r31_dly[DLY-1]),
    .angle(pitch_z), .mag(pitch_mag)
  );

  // output scaling, first half: partial products and radian rounding
  typedef struct packed {
    logic signed [47:0] ph;
    logic signed [48:0] pl;
    logic signed [20:0] rad;
  } scale_t;

  function automatic scale_t scale_a(input logic signed [ZW-1:0] z);
    scale_t s;
    logic signed [ZW:0] zr;
    zr    = (ZW+1)'(z) + (ZW+1)'(1 <<< 13);
    s.ph  = 48'($signed(z[ZW-1:17]) * DEG_Q24);
    s.pl  = 49'($signed({1'b0, z[16:0]}) * DEG_Q24);
    s.rad = 21'(zr >>> 14);
    return s;
  endfunction

  function automatic logic [24:0] scale_b(input scale_t s, input logic deg);
    logic signed [65:0] sum;
    logic signed [27:0] v;
    sum = (66'(s.ph) <<< 17) + 66'(s.pl) + (66'sd1 <<< 37);
    v   = deg ? 28'(sum >>> 38) : 28'(s.rad);
    if (v > 28'(ANGLE_LIMIT)) begin
      v = 28'(ANGLE_LIMIT);
    end else if (v < -28'(ANGLE_LIMIT)) begin
      v = -28'(ANGLE_LIMIT);
    end
    return v[24:0];
  endfunction

  scale_t sc_roll, sc_pitch, sc_yaw;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_roll  <= scale_a(roll_dly[DLY-1]);
      sc_pitch <= scale_a(pitch_z);
      sc_yaw   <= scale_a(yaw_dly[DLY-1]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {5'd0, scale_b(sc_yaw, output_in_degrees),
                       scale_b(sc_pitch, output_in_degrees),
                       scale_b(sc_roll, output_in_degrees)};
    end
  end

`ifndef NO_ASSERTIONS
  // roll and pitch never leave the saturation band, the pad stays zero and the roll magnitude is never negative
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[24:0]) <= ANGLE_LIMIT &&
                       $signed(m_axis_tdata[24:0]) >= -ANGLE_LIMIT))
    else $error("roll out of range");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[49:25]) <= ANGLE_LIMIT &&
                       $signed(m_axis_tdata[49:25]) >= -ANGLE_LIMIT))
    else $error("pitch out of range");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[79:75] == 5'd0)
    else $error("pad bits set");
  a_magnitude_sign: assert property (@(posedge clk) disable iff (rst)
    vld[CORDIC_LAT+1] |-> !roll_mag[VW-1])
    else $error("negative cordic magnitude");
`endif

endmodule
